>>> rtl/q15alu_pkg.sv
// ----------------------------------------------------------------------------
// q15alu_pkg
// shared types and constants of the saturating q15 arithmetic unit
// ----------------------------------------------------------------------------
package q15alu_pkg;

  localparam int unsigned DATA_W             = 16;
  localparam int unsigned FRAC_BITS          = 15;
  localparam int unsigned WIDE_W             = 2 * DATA_W;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;

  localparam logic signed [DATA_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] Q15_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } q15alu_cmd_e;

  // payload carried between pipeline stages
  typedef struct packed {
    logic                      is_div;
    logic                      div_zero;  // divisor is zero
    logic                      div_ovf;   // quotient magnitude >= 2^16
    logic                      a_neg;     // dividend sign
    logic                      q_neg;     // quotient sign
    logic signed [WIDE_W-1:0]  wide;      // add/sub/mul value scaled by 2^15
    logic [DATA_W-1:0]         dvsr;      // divisor magnitude
    logic [DATA_W-1:0]         rem;       // partial remainder
    logic [DATA_W-1:0]         dbits;     // dividend bits still to bring in
    logic [DATA_W-1:0]         quo;       // quotient bits so far
  } q15alu_pipe_t;

endpackage

>>> rtl/q15alu_req_if.sv
// ----------------------------------------------------------------------------
// q15alu_req_if
// request channel: command and two q15 operands
// ----------------------------------------------------------------------------
interface q15alu_req_if;
  logic                    valid;
  logic                    ready;
  q15alu_pkg::q15alu_cmd_e command;
  logic signed [15:0]      operand_a;
  logic signed [15:0]      operand_b;

  modport source (output valid, output command, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input command, input operand_a, input operand_b,
                  output ready);
endinterface

>>> rtl/q15alu_rsp_if.sv
// ----------------------------------------------------------------------------
// q15alu_rsp_if
// response channel: one saturated q15 result
// ----------------------------------------------------------------------------
interface q15alu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

>>> rtl/q15alu_front.sv
// ----------------------------------------------------------------------------
// q15alu_front
// first stage: add/sub, 16x16 product and divider setup
// ----------------------------------------------------------------------------
module q15alu_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  q15alu_pkg::q15alu_cmd_e  command_i,
  input  logic signed [15:0]       operand_a_i,
  input  logic signed [15:0]       operand_b_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output q15alu_pkg::q15alu_pipe_t data_o
);
  import q15alu_pkg::*;

  logic                     valid_q;
  q15alu_pipe_t             data_d, data_q;
  logic signed [DATA_W:0]   sum;
  logic signed [WIDE_W-1:0] prod;
  logic [DATA_W-1:0]        a_mag, b_mag;

  assign a_mag = operand_a_i[DATA_W-1] ? (~operand_a_i + 16'd1) : operand_a_i;
  assign b_mag = operand_b_i[DATA_W-1] ? (~operand_b_i + 16'd1) : operand_b_i;
  assign prod  = operand_a_i * operand_b_i;

  always_comb begin
    unique case (command_i)
      CMD_SUB: sum = 17'(operand_a_i) - 17'(operand_b_i);
      default: sum = 17'(operand_a_i) + 17'(operand_b_i);
    endcase
  end

  always_comb begin
    data_d.is_div   = (command_i == CMD_DIV);
    data_d.div_zero = (operand_b_i == '0);
    // quotient of (|a| << 15) / |b| reaches 2^16 exactly when |a| >= 2|b|
    data_d.div_ovf  = ({1'b0, a_mag} >= {b_mag, 1'b0});
    data_d.a_neg    = operand_a_i[DATA_W-1];
    data_d.q_neg    = operand_a_i[DATA_W-1] ^ operand_b_i[DATA_W-1];
    data_d.wide     = (command_i == CMD_MUL) ? prod : {sum, {FRAC_BITS{1'b0}}};
    data_d.dvsr     = b_mag;
    // top bits of the scaled dividend are already below the divisor
    data_d.rem      = {1'b0, a_mag[DATA_W-1:1]};
    data_d.dbits    = {a_mag[0], {(DATA_W-1){1'b0}}};
    data_d.quo      = '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/q15alu_div_stage.sv
// ----------------------------------------------------------------------------
// q15alu_div_stage
// one pipeline stage of the restoring divider, a few quotient bits per stage
// ----------------------------------------------------------------------------
module q15alu_div_stage #(
  parameter int unsigned BitsPerStage = q15alu_pkg::DIV_BITS_PER_STAGE
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  q15alu_pkg::q15alu_pipe_t data_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output q15alu_pkg::q15alu_pipe_t data_o
);
  import q15alu_pkg::*;

  logic              valid_q;
  q15alu_pipe_t      data_d, data_q;
  logic [DATA_W:0]   trial;
  logic              q_bit;

  always_comb begin
    data_d = data_i;
    trial  = '0;
    q_bit  = 1'b0;
    for (int unsigned i = 0; i < BitsPerStage; i++) begin
      trial = {data_d.rem, data_d.dbits[DATA_W-1]};
      q_bit = (trial >= {1'b0, data_d.dvsr});
      if (q_bit) begin
        data_d.rem = DATA_W'(trial - {1'b0, data_d.dvsr});
      end else begin
        data_d.rem = trial[DATA_W-1:0];
      end
      data_d.dbits = {data_d.dbits[DATA_W-2:0], 1'b0};
      data_d.quo   = {data_d.quo[DATA_W-2:0], q_bit};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/q15alu_out.sv
// ----------------------------------------------------------------------------
// q15alu_out
// last stage: scaling, quotient sign and saturation into the output register
// ----------------------------------------------------------------------------
module q15alu_out (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  q15alu_pkg::q15alu_pipe_t data_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [15:0]       result_o
);
  import q15alu_pkg::*;

  logic                     valid_q;
  logic signed [DATA_W-1:0] result_d, result_q;
  logic signed [DATA_W:0]   scaled;
  logic signed [DATA_W-1:0] arith_res, div_res;

  // arithmetic shift right by 15: floor for the product, exact for add/sub
  assign scaled = data_i.wide[WIDE_W-1:FRAC_BITS];

  always_comb begin
    if (scaled[DATA_W] != scaled[DATA_W-1]) begin
      arith_res = scaled[DATA_W] ? Q15_MIN : Q15_MAX;
    end else begin
      arith_res = scaled[DATA_W-1:0];
    end
  end

  always_comb begin
    priority if (data_i.div_zero) begin
      div_res = data_i.a_neg ? Q15_MIN : Q15_MAX;
    end else if (data_i.div_ovf) begin
      div_res = data_i.q_neg ? Q15_MIN : Q15_MAX;
    end else if (!data_i.q_neg) begin
      div_res = data_i.quo[DATA_W-1] ? Q15_MAX : data_i.quo;
    end else if (data_i.quo > 16'h8000) begin
      div_res = Q15_MIN;
    end else begin
      div_res = ~data_i.quo + 16'd1;
    end
  end

  assign result_d = data_i.is_div ? div_res : arith_res;
  assign ready_o  = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

>>> rtl/q15_saturating_alu_core.sv
// ----------------------------------------------------------------------------
// q15_saturating_alu_core
// pipelined saturating q15 add, subtract, multiply and divide
// ----------------------------------------------------------------------------
// usage
//   req_i carries a command (add, subtract, multiply, divide) and two signed
//   q15 operands; rsp_o returns one saturated q15 result per request, in
//   request order. both channels use valid/ready, a transfer happens when
//   both are high at a rising clock edge.
//   throughput: one request per cycle, any command, unless rsp_o stalls.
//   the pipeline is the front stage, the restoring divider stages (four
//   quotient bits each by default) and the output stage; the divider stages
//   set the pipeline depth, and every command takes the same path so
//   results never reorder.
//   each stage holds its own valid bit and advances whenever the stage after
//   it is empty or moving, so bubbles close up while the receiver stalls and
//   requests are still taken until every stage holds a request.
//   a stalled result stays on rsp_o unchanged until it is taken.
//   reset (rst_ni low, asynchronous) empties the pipeline; there is no other
//   state and no configuration.
// ----------------------------------------------------------------------------
module q15_saturating_alu_core #(
  parameter int unsigned DivBitsPerStage = q15alu_pkg::DIV_BITS_PER_STAGE
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  q15alu_req_if.sink   req_i,
  q15alu_rsp_if.source rsp_o
);
  import q15alu_pkg::*;

  localparam int unsigned DivStages = DATA_W / DivBitsPerStage;
  localparam int unsigned Depth     = DivStages + 2;
  localparam int unsigned CntW      = $clog2(Depth + 1);

  // stage k of the chain feeds stage k + 1; index 0 is the front stage output
  logic [DivStages:0] pipe_valid;
  logic [DivStages:0] pipe_ready;
  q15alu_pipe_t       pipe_data [DivStages+1];

  q15alu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (req_i.valid),
    .ready_o     (req_i.ready),
    .command_i   (req_i.command),
    .operand_a_i (req_i.operand_a),
    .operand_b_i (req_i.operand_b),
    .valid_o     (pipe_valid[0]),
    .ready_i     (pipe_ready[0]),
    .data_o      (pipe_data[0])
  );

  // restoring divider, DivBitsPerStage quotient bits per stage
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    q15alu_div_stage #(
      .BitsPerStage (DivBitsPerStage)
    ) u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pipe_valid[k]),
      .ready_o (pipe_ready[k]),
      .data_i  (pipe_data[k]),
      .valid_o (pipe_valid[k+1]),
      .ready_i (pipe_ready[k+1]),
      .data_o  (pipe_data[k+1])
    );
  end

  // saturation and the output register
  q15alu_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pipe_valid[DivStages]),
    .ready_o  (pipe_ready[DivStages]),
    .data_i   (pipe_data[DivStages]),
    .valid_o  (rsp_o.valid),
    .ready_i  (rsp_o.ready),
    .result_o (rsp_o.result)
  );

  // requests in flight, for the checks below
  logic            req_fire, rsp_fire;
  logic [CntW-1:0] inflight_d, inflight_q;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;

  always_comb begin
    inflight_d = inflight_q;
    if (req_fire && !rsp_fire) begin
      inflight_d = inflight_q + CntW'(1);
    end else if (rsp_fire && !req_fire) begin
      inflight_d = inflight_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // never more requests in flight than pipeline stages
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(Depth))
    else $error("more requests in flight than pipeline stages");

  // no result without a request behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (inflight_q != '0))
    else $error("result shown with no request in flight");

  // an empty output register lets the whole chain move
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("request stalled while output register is empty");

  // a full pipeline that cannot drain blocks new requests
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == CntW'(Depth)) && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while pipeline full and stalled");

endmodule

>>> verif/q15_saturating_alu_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q15_saturating_alu_core_tb
// self-checking bench for the pipelined saturating q15 arithmetic unit: a
// queue of requests (directed corner cases, then random) feeds a valid/ready
// driver, a monitor computes the saturated result of every accepted request
// and compares each returned result, in order, against it, while both sides
// idle and stall at random
// ----------------------------------------------------------------------------
module q15_saturating_alu_core_tb;
  import q15alu_pkg::*;

  // the number of random requests after the directed ones
  localparam int unsigned RANDOM_REQUESTS = 1750;
  // cycles with no transfer on either channel before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  // extra cycles after the last result, well past the pipeline depth
  localparam int unsigned DRAIN_CYCLES    = 16;

  typedef struct {
    q15alu_cmd_e        command;
    logic signed [15:0] operand_a;
    logic signed [15:0] operand_b;
  } alu_request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  q15alu_req_if req_if ();
  q15alu_rsp_if rsp_if ();

  q15_saturating_alu_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // requests waiting to be driven, results waiting to come back
  alu_request_t       pending_requests[$];
  logic signed [15:0] expected_results[$];

  int unsigned total_requests    = 0;
  int unsigned accepted_requests = 0;
  int unsigned matched_results   = 0;
  int unsigned error_count       = 0;
  int unsigned idle_cycles       = 0;

  // driver and stall state
  bit          req_taken     = 1'b0;  // request transfer seen at the last rising edge
  int unsigned req_gap       = 0;
  int unsigned req_burst     = 0;
  int unsigned rsp_stall     = 0;
  int unsigned rsp_burst     = 0;
  bit          flushing      = 1'b0;

  // ---------------------------------------------------------------------------
  // result prediction
  // ---------------------------------------------------------------------------

  function automatic logic signed [15:0] saturate_q15(longint value);
    if (value > longint'(Q15_MAX)) return Q15_MAX;
    if (value < longint'(Q15_MIN)) return Q15_MIN;
    return value[15:0];
  endfunction

  // everything is widened to 64 bits so nothing overflows before the clamp
  function automatic logic signed [15:0] q15_result(q15alu_cmd_e cmd,
                                                    logic signed [15:0] a,
                                                    logic signed [15:0] b);
    longint wa;
    longint wb;
    longint wide;
    wa = a;
    wb = b;
    case (cmd)
      CMD_ADD: wide = wa + wb;
      CMD_SUB: wide = wa - wb;
      // arithmetic shift of the full product rounds toward minus infinity
      CMD_MUL: wide = (wa * wb) >>> FRAC_BITS;
      default: begin
        // divide by zero saturates toward the sign of the dividend
        if (wb == 0) wide = (wa < 0) ? longint'(Q15_MIN) : longint'(Q15_MAX);
        // signed 64-bit division truncates toward zero
        else wide = (wa <<< FRAC_BITS) / wb;
      end
    endcase
    return saturate_q15(wide);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_request(q15alu_cmd_e cmd, logic signed [15:0] a,
                               logic signed [15:0] b);
    alu_request_t item;
    item.command   = cmd;
    item.operand_a = a;
    item.operand_b = b;
    pending_requests.push_back(item);
  endtask

  // operand mix: extremes, zero, tiny values and full-range values half the time
  function automatic logic signed [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return Q15_MAX;
      1:       return Q15_MIN;
      2:       return 16'sd0;
      3:       return 16'($signed($urandom_range(0, 8)) - 4);
      4:       return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // idle length for either side: mostly none or short, a few long, and now and
  // then a burst of back-to-back cycles with no idling at all
  function automatic int unsigned pick_idle(ref int unsigned burst_left);
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: changes inputs on the falling edge only
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    alu_request_t item;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      // nothing on the channel, or the current request went through
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        item = pending_requests.pop_front();
        req_if.valid     <= 1'b1;
        req_if.command   <= item.command;
        req_if.operand_a <= item.operand_a;
        req_if.operand_b <= item.operand_b;
        req_gap = pick_idle(req_burst);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random back-pressure, held open while draining
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (flushing) begin
      rsp_if.ready <= 1'b1;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_stall = pick_idle(rsp_burst);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    logic signed [15:0] want;
    req_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      // a taken request queues its saturated result
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(q15_result(req_if.command, req_if.operand_a,
                                              req_if.operand_b));
        accepted_requests++;
      end
      // a taken result must match the oldest one still owed
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result %0d returned with no request outstanding", rsp_if.result);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          matched_results++;
          if (rsp_if.result !== want) begin
            $error("result mismatch: expected %0d, got %0d", want, rsp_if.result);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a long stretch with no transfer at all means the pipeline hung
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles, %0d results still owed", idle_cycles,
             expected_results.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: build the request list, reset, run, drain, report
  // ---------------------------------------------------------------------------

  initial begin
    q15alu_cmd_e        cmd;
    logic signed [15:0] a;
    logic signed [15:0] b;

    req_if.valid     = 1'b0;
    req_if.command   = CMD_ADD;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    rsp_if.ready     = 1'b0;

    // add and subtract at the range limits, both clamp directions
    queue_request(CMD_ADD, Q15_MAX, Q15_MAX);
    queue_request(CMD_ADD, Q15_MIN, Q15_MIN);
    queue_request(CMD_ADD, Q15_MAX, Q15_MIN);
    queue_request(CMD_ADD, 16'sd0, 16'sd0);
    queue_request(CMD_SUB, Q15_MIN, Q15_MAX);
    queue_request(CMD_SUB, Q15_MAX, Q15_MIN);
    queue_request(CMD_SUB, 16'sd0, Q15_MIN);
    queue_request(CMD_SUB, -16'sd1, Q15_MAX);
    // minus one times minus one overflows to 32768 and must clamp
    queue_request(CMD_MUL, Q15_MIN, Q15_MIN);
    queue_request(CMD_MUL, Q15_MIN, Q15_MAX);
    queue_request(CMD_MUL, Q15_MAX, Q15_MAX);
    queue_request(CMD_MUL, 16'sd16384, 16'sd16384);
    // small negative products round down to -1, not toward zero
    queue_request(CMD_MUL, -16'sd1, 16'sd1);
    queue_request(CMD_MUL, -16'sd3, 16'sd5);
    // divide by zero with zero, positive and negative dividends
    queue_request(CMD_DIV, 16'sd0, 16'sd0);
    queue_request(CMD_DIV, 16'sd100, 16'sd0);
    queue_request(CMD_DIV, Q15_MAX, 16'sd0);
    queue_request(CMD_DIV, -16'sd1, 16'sd0);
    queue_request(CMD_DIV, Q15_MIN, 16'sd0);
    // quotients past the range, then truncation toward zero on both signs
    queue_request(CMD_DIV, Q15_MIN, -16'sd1);
    queue_request(CMD_DIV, Q15_MIN, Q15_MIN);
    queue_request(CMD_DIV, Q15_MAX, 16'sd1);
    queue_request(CMD_DIV, 16'sd1, 16'sd3);
    queue_request(CMD_DIV, -16'sd1, 16'sd3);
    queue_request(CMD_DIV, 16'sd16384, Q15_MIN);

    repeat (RANDOM_REQUESTS) begin
      cmd = q15alu_cmd_e'($urandom_range(0, 3));
      a   = pick_operand();
      b   = pick_operand();
      // shrink half the dividends so most divisions land inside the range
      if (cmd == CMD_DIV && $urandom_range(0, 1)) a = a >>> $urandom_range(0, 15);
      queue_request(cmd, a, b);
    end
    total_requests = pending_requests.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_requests == total_requests && matched_results == total_requests);
    flushing = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> q15_saturating_alu_core.f
rtl/q15alu_pkg.sv
rtl/q15alu_req_if.sv
rtl/q15alu_rsp_if.sv
rtl/q15alu_front.sv
rtl/q15alu_div_stage.sv
rtl/q15alu_out.sv
rtl/q15_saturating_alu_core.sv
verif/q15_saturating_alu_core_tb.sv
